[hw/rtl/spe_pkg.sv]
// shared types and constants of the sample period estimator
`default_nettype none

package spe_pkg;

	// fixed field widths
	localparam int TIME_W   = 64;
	localparam int PERIOD_W = 20;
	localparam int OBS_W    = 21;
	localparam int WIN_W    = 24;
	localparam int APB_DW   = 32;

	// result status codes
	typedef enum logic [1:0] {
		ST_NONE = 2'd0,
		ST_PROV = 2'd1,
		ST_ACQ  = 2'd2,
		ST_TRK  = 2'd3
	} status_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic clr_anchor;
		logic set_anchor;
		logic diff;
		logic div_obs;
		logic latch;
		logic set_period_obs;
		logic seed_init;
		logic seed_wr;
		logic ring_rd;
		logic ring_upd;
		logic div_avg;
		logic set_period_avg;
	} cmd_t;

	// datapath status seen by the controller
	typedef struct packed {
		logic req_clear;
		logic reanchor;
		logic div_done;
		logic obs_valid;
		logic span_short;
		logic acquired;
		logic seed_last;
	} dp_st_t;

endpackage

`default_nettype wire

[hw/rtl/sample_period_estimator_core.sv]
// Sample period estimator, top level with configuration registers and output register.
// Each input transfer is handled to completion before the next one is taken. A clear or
// re-anchor item sets or clears the anchor and goes to the result. An edge that yields an
// observation passes through the bit-serial divider in the datapath, which resolves one
// quotient bit per cycle over a (65 + FRAC_BITS)-bit dividend. A provisional update sets
// the period from the observation, a re-anchor at the window end sets the anchor,
// acquisition writes every entry of the history ring, and a tracking update reads the
// ring, writes the ring and takes the ring average, as a multiply by the reciprocal of
// HISTORY_DEPTH. The result sits in an output register, so a new item is taken while it
// waits; a result that is ready while the register still holds the previous one waits in
// the controller until it is taken.
`default_nettype none

module sample_period_estimator_core #(
	parameter int HISTORY_DEPTH = 8,
	parameter int FRAC_BITS     = 5
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// configuration port
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [3:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	// input stream
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [127:0] s_tdata,  // edge_time_us[63:0], edge_count[127:64]
	input  wire logic         s_tuser,  // req_type
	// result stream
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [23:0]       m_tdata   // status[1:0], period[21:2], is_acquired[22], 0
);

	import spe_pkg::*;

	localparam logic [1:0] REG_ACQ_WIN = 2'd0;
	localparam logic [1:0] REG_TRK_WIN = 2'd1;
	localparam logic [1:0] REG_PMIN    = 2'd2;
	localparam logic [1:0] REG_PMAX    = 2'd3;

	localparam logic [WIN_W-1:0]    ACQ_RST  = WIN_W'(64000);
	localparam logic [WIN_W-1:0]    TRK_RST  = WIN_W'(1000000);
	localparam logic [PERIOD_W-1:0] PMIN_RST = PERIOD_W'((450 << FRAC_BITS) & 'hFFFFF);
	localparam logic [PERIOD_W-1:0] PMAX_RST = PERIOD_W'((550 << FRAC_BITS) & 'hFFFFF);

	logic [WIN_W-1:0]    acq_win_q;
	logic [WIN_W-1:0]    trk_win_q;
	logic [PERIOD_W-1:0] pmin_q;
	logic [PERIOD_W-1:0] pmax_q;

	logic                cfg_wr;
	logic                in_take;
	logic                in_ready;
	logic                res_load;
	logic                out_free;
	cmd_t                cmd;
	dp_st_t              st;
	status_t             res_status;
	logic [PERIOD_W-1:0] period;
	logic                acquired;

	logic                m_tvalid_q;
	logic [23:0]         m_tdata_q;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acq_win_q <= ACQ_RST;
			trk_win_q <= TRK_RST;
			pmin_q    <= PMIN_RST;
			pmax_q    <= PMAX_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_ACQ_WIN: acq_win_q <= pwdata[WIN_W-1:0];
				REG_TRK_WIN: trk_win_q <= pwdata[WIN_W-1:0];
				REG_PMIN:    pmin_q    <= pwdata[PERIOD_W-1:0];
				REG_PMAX:    pmax_q    <= pwdata[PERIOD_W-1:0];
				default:     ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (paddr[3:2])
			REG_ACQ_WIN: prdata = APB_DW'(acq_win_q);
			REG_TRK_WIN: prdata = APB_DW'(trk_win_q);
			REG_PMIN:    prdata = APB_DW'(pmin_q);
			REG_PMAX:    prdata = APB_DW'(pmax_q);
			default:     prdata = '0;
		endcase
	end

	assign s_tready = in_ready;
	assign in_take  = s_tvalid && in_ready;
	assign out_free = !m_tvalid_q || m_tready;

	spe_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_take    (in_take),
		.st         (st),
		.out_free   (out_free),
		.cmd        (cmd),
		.res_status (res_status),
		.in_ready   (in_ready),
		.res_load   (res_load)
	);

	spe_datapath #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.FRAC_BITS     (FRAC_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_take  (in_take),
		.in_req   (s_tuser),
		.in_time  (s_tdata[63:0]),
		.in_cnt   (s_tdata[127:64]),
		.acq_win  (acq_win_q),
		.trk_win  (trk_win_q),
		.pmin     (pmin_q),
		.pmax     (pmax_q),
		.cmd      (cmd),
		.st       (st),
		.period   (period),
		.acquired (acquired)
	);

	// result output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			m_tdata_q <= {1'b0, acquired, period, res_status};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> (!m_tvalid_q || m_tready))
		else $error("result register overwritten before transfer");

endmodule

`default_nettype wire

[hw/rtl/spe_div.sv]
// bit-serial restoring divider with a saturating quotient
`default_nettype none

module spe_div #(
	parameter int DVD_W = 69,
	parameter int DVS_W = 64,
	parameter int Q_W   = 21
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [DVD_W-1:0]               dividend,
	input  wire logic [DVS_W-1:0]               divisor,
	input  wire logic [$clog2(DVD_W+1)-1:0]     iters,
	output logic                                done,
	output logic [Q_W-1:0]                      quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [Q_W-1:0]   q_q;
	logic             sat_q;

	logic [DVS_W:0]   rem_sh;
	logic [DVS_W:0]   diff;
	logic             ge;

	// one quotient bit per cycle
	always_comb begin
		rem_sh = {rem_q, dvd_q[DVD_W-1]};
		diff   = rem_sh - {1'b0, dvs_q};
		ge     = ~diff[DVS_W];
	end

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= iters;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift and subtract
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
			q_q   <= '0;
			sat_q <= 1'b0;
		end else if (run_q) begin
			dvd_q <= dvd_q << 1;
			rem_q <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
			q_q   <= {q_q[Q_W-2:0], ge};
			sat_q <= sat_q | q_q[Q_W-1];
		end
	end

	assign done     = done_q;
	assign quotient = sat_q ? '1 : q_q;

	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(run_q))
		else $error("divider finished without running");

endmodule

`default_nettype wire

[hw/rtl/spe_datapath.sv]
// anchor, observation, history ring and period registers
`default_nettype none

module spe_datapath #(
	parameter int HISTORY_DEPTH = 8,
	parameter int FRAC_BITS     = 5
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_take,
	input  wire logic                               in_req,
	input  wire logic [spe_pkg::TIME_W-1:0]         in_time,
	input  wire logic [spe_pkg::TIME_W-1:0]         in_cnt,
	input  wire logic [spe_pkg::WIN_W-1:0]          acq_win,
	input  wire logic [spe_pkg::WIN_W-1:0]          trk_win,
	input  wire logic [spe_pkg::PERIOD_W-1:0]       pmin,
	input  wire logic [spe_pkg::PERIOD_W-1:0]       pmax,
	input  wire spe_pkg::cmd_t                      cmd,
	output spe_pkg::dp_st_t                         st,
	output logic [spe_pkg::PERIOD_W-1:0]            period,
	output logic                                    acquired
);

	import spe_pkg::*;

	localparam int DVD_W   = TIME_W + FRAC_BITS + 1;
	localparam int CNT_W   = $clog2(DVD_W + 1);
	localparam int IDX_W   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int TOT_W   = PERIOD_W + $clog2(HISTORY_DEPTH);
	localparam int AVG_W   = TOT_W + 1;
	localparam int LOG_D   = $clog2(HISTORY_DEPTH);
	localparam int RCP_W   = AVG_W + 1;
	localparam int PROD_W  = 2 * AVG_W + 1;
	localparam int NOM_INT = (500 << FRAC_BITS) & 'hFFFFF;
	localparam logic [PERIOD_W-1:0] NOMINAL = PERIOD_W'(NOM_INT);
	localparam logic [TOT_W-1:0]    TOT_RST = TOT_W'(HISTORY_DEPTH * NOM_INT);
	// ceil(2^(AVG_W+LOG_D) / HISTORY_DEPTH) gives an exact floor division over AVG_W bits
	localparam longint unsigned RCP_INT = ((64'd1 << (AVG_W + LOG_D)) +
		64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH);
	localparam logic [RCP_W-1:0] RECIP = RCP_W'(RCP_INT);

	// item and anchor registers
	logic                in_req_q;
	logic [TIME_W-1:0]   in_time_q;
	logic [TIME_W-1:0]   in_cnt_q;
	logic [TIME_W-1:0]   anchor_time_q;
	logic [TIME_W-1:0]   anchor_cnt_q;
	logic [TIME_W-1:0]   dt_q;
	logic [TIME_W-1:0]   dn_q;

	// observation and estimate
	logic [OBS_W-1:0]    obs_q;
	logic                valid_q;
	logic                short_q;
	logic                acq_q;
	logic [PERIOD_W-1:0] period_q;
	logic [TOT_W-1:0]    total_q;
	logic [IDX_W-1:0]    pos_q;
	logic [PERIOD_W-1:0] avg_q;

	// history ring
	logic [PERIOD_W-1:0]      mem [HISTORY_DEPTH];
	logic [HISTORY_DEPTH-1:0] vld_q;
	logic [PERIOD_W-1:0]      rd_q;
	logic                     rd_vld_q;

	logic [IDX_W-1:0]    pos_nxt;
	logic [PERIOD_W-1:0] old_entry;
	logic [DVD_W-1:0]    obs_dvd;
	logic [AVG_W-1:0]    avg_dvd;
	logic [PROD_W-1:0]   avg_prod;
	logic                div_start;
	logic [DVD_W-1:0]    div_dvd;
	logic [TIME_W-1:0]   div_dvs;
	logic [CNT_W-1:0]    div_iters;
	logic                div_done;
	logic [OBS_W-1:0]    div_quot;
	logic [TIME_W-1:0]   win_ext;

	// divider operands and the rounded ring average
	always_comb begin
		obs_dvd   = (DVD_W'(dt_q) << FRAC_BITS) + DVD_W'(dn_q >> 1);
		avg_dvd   = AVG_W'(total_q) + AVG_W'(HISTORY_DEPTH / 2);
		avg_prod  = PROD_W'(avg_dvd) * PROD_W'(RECIP);
		div_start = cmd.div_obs;
		div_dvd   = obs_dvd;
		div_dvs   = dn_q;
		div_iters = CNT_W'(DVD_W);
	end

	spe_div #(
		.DVD_W (DVD_W),
		.DVS_W (TIME_W),
		.Q_W   (OBS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.iters    (div_iters),
		.done     (div_done),
		.quotient (div_quot)
	);

	// ring index and the entry being replaced
	always_comb begin
		pos_nxt   = (pos_q == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : pos_q + 1'b1;
		old_entry = rd_vld_q ? rd_q : NOMINAL;
		win_ext   = TIME_W'(acq_q ? trk_win : acq_win);
	end

	// incoming item payload, deltas, observation and ring average
	always_ff @(posedge clk) begin
		if (in_take) begin
			in_req_q  <= in_req;
			in_time_q <= in_time;
			in_cnt_q  <= in_cnt;
		end
		if (cmd.diff) begin
			dt_q <= in_time_q - anchor_time_q;
			dn_q <= in_cnt_q - anchor_cnt_q;
		end
		if (cmd.latch) begin
			obs_q <= div_quot;
		end
		if (cmd.div_avg) begin
			avg_q <= avg_prod[AVG_W + LOG_D +: PERIOD_W];
		end
	end

	// estimator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_time_q <= '0;
			anchor_cnt_q  <= '0;
			valid_q       <= 1'b0;
			short_q       <= 1'b0;
			acq_q         <= 1'b0;
			period_q      <= NOMINAL;
			total_q       <= TOT_RST;
			pos_q         <= '0;
			vld_q         <= '0;
			rd_vld_q      <= 1'b0;
		end else begin
			if (cmd.clr_anchor) begin
				anchor_time_q <= '0;
				anchor_cnt_q  <= '0;
			end
			if (cmd.set_anchor) begin
				anchor_time_q <= in_time_q;
				anchor_cnt_q  <= in_cnt_q;
			end
			if (cmd.latch) begin
				valid_q <= (div_quot >= {1'b0, pmin}) && (div_quot <= {1'b0, pmax});
				short_q <= dt_q < win_ext;
			end
			if (cmd.set_period_obs) begin
				period_q <= obs_q[PERIOD_W-1:0];
			end
			if (cmd.set_period_avg) begin
				period_q <= avg_q;
			end
			if (cmd.seed_init) begin
				acq_q   <= 1'b1;
				pos_q   <= '0;
				total_q <= '0;
			end
			if (cmd.seed_wr) begin
				total_q <= total_q + TOT_W'(obs_q[PERIOD_W-1:0]);
				pos_q   <= pos_nxt;
			end
			if (cmd.ring_rd) begin
				rd_vld_q <= vld_q[pos_q];
			end
			if (cmd.ring_upd) begin
				total_q <= total_q - TOT_W'(old_entry) + TOT_W'(obs_q[PERIOD_W-1:0]);
				pos_q   <= pos_nxt;
			end
			if (cmd.seed_wr || cmd.ring_upd) begin
				vld_q[pos_q] <= 1'b1;
			end
		end
	end

	// history memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (cmd.seed_wr || cmd.ring_upd) begin
			mem[pos_q] <= obs_q[PERIOD_W-1:0];
		end
		if (cmd.ring_rd) begin
			rd_q <= mem[pos_q];
		end
	end

	// status toward the controller
	always_comb begin
		st.req_clear  = in_req_q;
		st.reanchor   = (anchor_time_q == '0) || (in_time_q <= anchor_time_q) ||
		                (in_cnt_q <= anchor_cnt_q);
		st.div_done   = div_done;
		st.obs_valid  = valid_q;
		st.span_short = short_q;
		st.acquired   = acq_q;
		st.seed_last  = pos_q == IDX_W'(HISTORY_DEPTH - 1);
	end

	assign period   = period_q;
	assign acquired = acq_q;

	a_upd_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ring_upd |-> $past(cmd.ring_rd))
		else $error("ring update without a preceding read");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.seed_wr || cmd.ring_upd) |=> pos_q <= IDX_W'(HISTORY_DEPTH - 1))
		else $error("ring position out of range");

endmodule

`default_nettype wire

[hw/rtl/spe_ctrl.sv]
// controller state machine of the sample period estimator
`default_nettype none

module spe_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_take,
	input  wire spe_pkg::dp_st_t   st,
	input  wire logic              out_free,
	output spe_pkg::cmd_t          cmd,
	output spe_pkg::status_t       res_status,
	output logic                   in_ready,
	output logic                   res_load
);

	import spe_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE,
		S_EVAL,
		S_CLR,
		S_ANCH,
		S_DIFF,
		S_OBS,
		S_DIVW,
		S_LATCH,
		S_DEC,
		S_PROV,
		S_SEED0,
		S_SEED,
		S_TRD,
		S_TUPD,
		S_AVG,
		S_AVGS,
		S_RESP
	} state_t;

	state_t  state_q;
	status_t status_q;
	logic    pv;

	assign pv = st.obs_valid && !st.acquired;

	// state and result status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			status_q <= ST_NONE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					status_q <= ST_NONE;
					if (st.req_clear) begin
						state_q <= S_CLR;
					end else if (st.reanchor) begin
						state_q <= S_ANCH;
					end else begin
						state_q <= S_DIFF;
					end
				end
				S_CLR:   state_q <= S_RESP;
				S_ANCH:  state_q <= S_RESP;
				S_DIFF:  state_q <= S_OBS;
				S_OBS:   state_q <= S_DIVW;
				S_DIVW: begin
					if (st.div_done) begin
						state_q <= S_LATCH;
					end
				end
				S_LATCH: state_q <= S_DEC;
				// choose the update from span and validity
				S_DEC: begin
					if (st.span_short) begin
						status_q <= pv ? ST_PROV : ST_NONE;
						state_q  <= pv ? S_PROV : S_RESP;
					end else if (pv) begin
						status_q <= ST_ACQ;
						state_q  <= S_SEED0;
					end else if (st.obs_valid) begin
						status_q <= ST_TRK;
						state_q  <= S_TRD;
					end else begin
						status_q <= ST_NONE;
						state_q  <= S_ANCH;
					end
				end
				S_PROV:  state_q <= S_RESP;
				S_SEED0: state_q <= S_SEED;
				S_SEED: begin
					if (st.seed_last) begin
						state_q <= S_RESP;
					end
				end
				S_TRD:   state_q <= S_TUPD;
				S_TUPD:  state_q <= S_AVG;
				S_AVG:   state_q <= S_AVGS;
				S_AVGS:  state_q <= S_RESP;
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// command decode
	always_comb begin
		cmd = '0;
		case (state_q)
			S_CLR:   cmd.clr_anchor = 1'b1;
			S_ANCH:  cmd.set_anchor = 1'b1;
			S_DIFF:  cmd.diff = 1'b1;
			S_OBS:   cmd.div_obs = 1'b1;
			S_LATCH: cmd.latch = 1'b1;
			S_PROV:  cmd.set_period_obs = 1'b1;
			S_SEED0: begin
				cmd.set_anchor     = 1'b1;
				cmd.seed_init      = 1'b1;
				cmd.set_period_obs = 1'b1;
			end
			S_SEED:  cmd.seed_wr = 1'b1;
			S_TRD: begin
				cmd.set_anchor = 1'b1;
				cmd.ring_rd    = 1'b1;
			end
			S_TUPD:  cmd.ring_upd = 1'b1;
			S_AVG:   cmd.div_avg = 1'b1;
			S_AVGS:  cmd.set_period_avg = 1'b1;
			default: cmd = '0;
		endcase
	end

	assign in_ready   = state_q == S_IDLE;
	assign res_load   = (state_q == S_RESP) && out_free;
	assign res_status = status_q;

	a_resp_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP && !out_free) |=> state_q == S_RESP)
		else $error("result dropped while output register busy");

endmodule

`default_nettype wire

[bench/sample_period_estimator_core_test.sv]
// testbench for the sample period estimator core: directed table, then random edge streams
`timescale 1ns / 1ps

module sample_period_estimator_core_test;
	import spe_pkg::*;

	localparam int HISTORY_DEPTH = 8;
	localparam int FRAC_BITS     = 5;
	localparam int QUIET_LIMIT   = 5000;
	localparam int PHASE_ITEMS   = 330;
	localparam int ROW_COUNT     = 14;
	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	// request kinds carried in tuser
	typedef enum logic {
		REQ_EDGE  = 1'b0,
		REQ_CLEAR = 1'b1
	} req_t;

	// register indexes of the configuration port
	typedef enum logic [1:0] {
		REG_ACQ_WINDOW = 2'd0,
		REG_TRK_WINDOW = 2'd1,
		REG_PERIOD_MIN = 2'd2,
		REG_PERIOD_MAX = 2'd3
	} reg_idx_t;

	typedef struct packed {
		status_t     status;
		logic [19:0] period;
		logic        acquired;
	} period_result_t;

	typedef struct packed {
		logic           pinned;
		period_result_t res;
	} pinned_result_t;

	typedef struct packed {
		req_t           req;
		logic [63:0]    edge_time;
		logic [63:0]    edge_cnt;
		logic           pinned;
		period_result_t res;
	} stim_row_t;

	logic         clk;
	logic         arst_n   = 1'b0;
	logic         psel     = 1'b0;
	logic         penable  = 1'b0;
	logic         pwrite   = 1'b0;
	logic [3:0]   paddr    = '0;
	logic [31:0]  pwdata   = '0;
	logic [31:0]  prdata;
	logic         pready;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [127:0] s_tdata  = '0;  // edge_time_us[63:0], edge_count[127:64]
	logic         s_tuser  = 1'b0; // req_type
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [23:0]  m_tdata;        // status[1:0], period[21:2], is_acquired[22], 0

	// predictor copy of the configuration
	logic [23:0] acq_window;
	logic [23:0] trk_window;
	logic [19:0] min_q5;
	logic [19:0] max_q5;

	// predictor copy of the state
	logic [63:0] anchor_time_us;
	logic [63:0] anchor_cnt;
	logic        acquired;
	logic [19:0] est_period;
	logic [19:0] hist [HISTORY_DEPTH];
	logic [22:0] hist_sum;
	logic [2:0]  hist_pos;

	period_result_t period_results_q [$];
	pinned_result_t pinned_q [$];
	int fails        = 0;
	int quiet_cycles = 0;
	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;

	// random stream generator state
	logic [63:0] cur_time;
	logic [63:0] cur_count;
	int          seq_period;
	bit          seq_exact;

	// unacquired special cases at the reset configuration
	stim_row_t directed_rows [ROW_COUNT] = '{
		'{REQ_CLEAR, ALL_ONES, ALL_ONES, 1'b1, '{ST_NONE, 20'd16000, 1'b0}},
		'{REQ_EDGE,  64'd0,    64'd5,    1'b1, '{ST_NONE, 20'd16000, 1'b0}},
		'{REQ_EDGE,  64'd1000, 64'd10,   1'b1, '{ST_NONE, 20'd16000, 1'b0}},
		'{REQ_EDGE,  64'd1500, 64'd11,   1'b1, '{ST_PROV, 20'd16000, 1'b0}},
		'{REQ_EDGE,  64'd1990, 64'd12,   1'b0, '0},
		'{REQ_EDGE,  64'd900,  64'd20,   1'b0, '0},
		'{REQ_EDGE,  64'd2000, 64'd20,   1'b0, '0},
		'{REQ_EDGE,  64'd2100, 64'd21,   1'b0, '0},
		'{REQ_EDGE,  ALL_ONES, 64'd22,   1'b0, '0},
		'{REQ_EDGE,  64'd5,    64'd23,   1'b0, '0},
		'{REQ_CLEAR, 64'd0,    64'd0,    1'b0, '0},
		'{REQ_EDGE,  64'd1,    64'd0,    1'b0, '0},
		'{REQ_EDGE,  64'd5001, 64'd10,   1'b1, '{ST_PROV, 20'd16000, 1'b0}},
		'{REQ_EDGE,  64'd5501, 64'd11,   1'b0, '0}
	};

	sample_period_estimator_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// rounded quotient of the deltas in q5, saturated to 21 bits
	function automatic logic [20:0] observed_period(logic [63:0] dt, logic [63:0] dn);
		logic [127:0] num;
		logic [127:0] quo;
		num = ({64'd0, dt} << FRAC_BITS) + {64'd0, dn >> 1};
		quo = num / {64'd0, dn};
		return (quo > 128'h1F_FFFF) ? 21'h1F_FFFF : quo[20:0];
	endfunction

	function automatic void reset_predictor();
		acq_window     = 24'd64000;
		trk_window     = 24'd1000000;
		min_q5         = 20'd14400;
		max_q5         = 20'd17600;
		anchor_time_us = '0;
		anchor_cnt     = '0;
		acquired       = 1'b0;
		est_period     = 20'd16000;
		for (int i = 0; i < HISTORY_DEPTH; i++)
			hist[i] = 20'd16000;
		hist_sum = 23'(16000 * HISTORY_DEPTH);
		hist_pos = '0;
	endfunction

	// next period estimate for one accepted request
	function automatic period_result_t predict_period(req_t req, logic [63:0] t,
			logic [63:0] n);
		period_result_t r;
		logic [63:0]    dt;
		logic [20:0]    obs;
		logic           valid;
		logic [23:0]    window;
		logic [23:0]    avg;
		r.status = ST_NONE;
		if (req == REQ_CLEAR) begin
			anchor_time_us = '0;
			anchor_cnt     = '0;
		end else if (anchor_time_us == 0 || t <= anchor_time_us || n <= anchor_cnt) begin
			anchor_time_us = t;
			anchor_cnt     = n;
		end else begin
			dt     = t - anchor_time_us;
			obs    = observed_period(dt, n - anchor_cnt);
			valid  = (obs >= {1'b0, min_q5}) && (obs <= {1'b0, max_q5});
			window = acquired ? trk_window : acq_window;
			if (!acquired && valid)
				est_period = obs[19:0];
			if (dt < {40'd0, window}) begin
				if (!acquired && valid)
					r.status = ST_PROV;
			end else begin
				anchor_time_us = t;
				anchor_cnt     = n;
				// first valid span over the window seeds the whole history
				if (valid && !acquired) begin
					for (int i = 0; i < HISTORY_DEPTH; i++)
						hist[i] = obs[19:0];
					hist_sum   = 23'(obs[19:0] * HISTORY_DEPTH);
					hist_pos   = '0;
					est_period = obs[19:0];
					acquired   = 1'b1;
					r.status   = ST_ACQ;
				end else if (valid) begin
					hist_sum       = hist_sum - hist[hist_pos] + obs[19:0];
					hist[hist_pos] = obs[19:0];
					hist_pos       = hist_pos + 3'd1;
					avg            = 24'((24'(hist_sum) + HISTORY_DEPTH / 2) / HISTORY_DEPTH);
					est_period     = avg[19:0];
					r.status       = ST_TRK;
				end
			end
		end
		r.period   = est_period;
		r.acquired = acquired;
		return r;
	endfunction

	function automatic logic [63:0] random64();
		return {$urandom, $urandom};
	endfunction

	// fresh base point and period for a well-formed edge stream
	function automatic void new_sequence();
		cur_time   = random64() >> $urandom_range(63, 2);
		cur_count  = random64() >> $urandom_range(63, 2);
		seq_exact  = ($urandom_range(3) == 0);
		seq_period = seq_exact ? 16000 : $urandom_range(21000, 12000);
	endfunction

	// receiver that stalls at the configured rate
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= rx_stall_pct);

	// predict on each input transfer, check each result transfer
	always @(posedge clk) begin
		period_result_t est;
		pinned_result_t pin;
		if (arst_n && s_tvalid && s_tready) begin
			est = predict_period(req_t'(s_tuser), s_tdata[63:0], s_tdata[127:64]);
			if (pinned_q.size() != 0) begin
				pin = pinned_q.pop_front();
				if (pin.pinned)
					est = pin.res;
			end
			period_results_q.push_back(est);
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (period_results_q.size() == 0) begin
				$error("result with nothing expected: m_tdata %h", m_tdata);
				fails++;
			end else begin
				est = period_results_q.pop_front();
				if (m_tdata[1:0] !== est.status) begin
					$error("status: expected %0d, got %0d", est.status, m_tdata[1:0]);
					fails++;
				end
				if (m_tdata[21:2] !== est.period) begin
					$error("period: expected %0d, got %0d", est.period, m_tdata[21:2]);
					fails++;
				end
				if (m_tdata[22] !== est.acquired) begin
					$error("is_acquired: expected %0d, got %0d", est.acquired, m_tdata[22]);
					fails++;
				end
			end
		end
	end

	// watchdog on cycles with no transfer anywhere
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_ACQ_WINDOW: acq_window = value[23:0];
			REG_TRK_WINDOW: trk_window = value[23:0];
			REG_PERIOD_MIN: min_q5     = value[19:0];
			REG_PERIOD_MAX: max_q5     = value[19:0];
			default:        ;
		endcase
		@(posedge clk);
	endtask

	// one input transfer, with random idle cycles ahead of it
	task automatic send_item(req_t req, logic [63:0] t, logic [63:0] n, logic pinned,
			period_result_t res);
		pinned_result_t pin;
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		pin.pinned = pinned;
		pin.res    = res;
		pinned_q.push_back(pin);
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {n, t};
		do @(posedge clk); while (!s_tready);
	endtask

	// stop sending and let every expected result drain
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (period_results_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_random(int count);
		int          kind;
		logic [63:0] dn;
		logic [63:0] dt;
		int          jit;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(99);
			if (kind < 80) begin
				// well-formed edge: small steps, sometimes a long jump over the windows
				dn = (kind < 70) ? 64'($urandom_range(64, 1)) : 64'($urandom_range(60000, 500));
				dt = (dn * seq_period + 16) >> FRAC_BITS;
				if (!seq_exact) begin
					jit = $urandom_range(4);
					dt  = dt + jit - 2;
				end
				cur_time  = cur_time + dt;
				cur_count = cur_count + dn;
				send_item(REQ_EDGE, cur_time, cur_count, 1'b0, '0);
			end else if (kind < 85) begin
				send_item(REQ_CLEAR, random64(), random64(), 1'b0, '0);
				new_sequence();
			end else if (kind < 90) begin
				// timestamp or count going backwards
				if (kind % 2 == 0)
					send_item(REQ_EDGE, cur_time - $urandom_range(20000), cur_count + 1,
						1'b0, '0);
				else
					send_item(REQ_EDGE, cur_time + 1, cur_count - $urandom_range(3),
						1'b0, '0);
			end else if (kind < 95) begin
				send_item(req_t'($urandom_range(1)), random64(), random64(), 1'b0, '0);
			end else begin
				new_sequence();
				send_item(REQ_EDGE, cur_time, cur_count, 1'b0, '0);
			end
		end
	endtask

	task automatic run_phase(int tx_pct, int rx_pct, logic [31:0] acq, logic [31:0] trk,
			logic [31:0] pmin, logic [31:0] pmax);
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		write_reg(REG_ACQ_WINDOW, acq);
		write_reg(REG_TRK_WINDOW, trk);
		write_reg(REG_PERIOD_MIN, pmin);
		write_reg(REG_PERIOD_MAX, pmax);
		new_sequence();
		run_random(PHASE_ITEMS);
		drain();
	endtask

	initial begin
		reset_predictor();
		tx_idle_pct  = 20;
		rx_stall_pct = 47;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at the reset configuration
		for (int i = 0; i < ROW_COUNT; i++)
			send_item(directed_rows[i].req, directed_rows[i].edge_time,
				directed_rows[i].edge_cnt, directed_rows[i].pinned, directed_rows[i].res);
		drain();

		// empty range with a zero acquire window, then widest range with longest windows
		run_phase(20, 47, 0, 1, 17600, 14400);
		run_phase(20, 47, 24'hFF_FFFF, 24'hFF_FFFF, 0, 20'hF_FFFF);
		// reset-like settings, then short windows and a wider range
		run_phase(47, 20, 64000, 1000000, 14400, 17600);
		run_phase(47, 20, 1, 2000, 12000, 20000);
		// single valid period, then random windows over the full range
		run_phase(0, 0, 0, 0, 16000, 16000);
		run_phase(0, 0, $urandom_range(50000, 1), $urandom_range(100000, 1), 0, 20'hF_FFFF);

		repeat (100) @(posedge clk);
		if (fails == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
